@@ rtl/core/slbm_pkg.sv @@
// Types and constants shared by the serial-loaded bank mapper.
`default_nettype none
package slbm_pkg;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] bus_addr;
    logic [7:0]  bus_data;
  } req_word_t;

  typedef struct packed {
    logic [2:0]  target;
    logic [17:0] mem_addr;
    logic        write_enable;
    logic [7:0]  write_byte;
    logic [1:0]  mirroring;
  } rsp_word_t;

  typedef struct packed {
    logic [4:0] prg_rom_banks;
    logic       has_prg_ram;
    logic       chr_is_ram;
  } cfg_t;

  typedef struct packed {
    logic [1:0] mirror_sel;
    logic [1:0] prg_bank_mode;
    logic       chr_bank_mode;
    logic [4:0] chr_bank_lo;
    logic [4:0] chr_bank_hi;
    logic [3:0] prg_bank;
    logic       prg_ram_on;
  } bank_state_t;

  // access kinds
  localparam logic [1:0] KIND_CPU_WR = 2'd0;
  localparam logic [1:0] KIND_CPU_RD = 2'd1;
  localparam logic [1:0] KIND_VID_RD = 2'd2;
  localparam logic [1:0] KIND_VID_WR = 2'd3;

  // result targets
  localparam logic [2:0] TGT_NONE    = 3'd0;
  localparam logic [2:0] TGT_PRG_RAM = 3'd1;
  localparam logic [2:0] TGT_PRG_ROM = 3'd2;
  localparam logic [2:0] TGT_CHR_ROM = 3'd3;
  localparam logic [2:0] TGT_CHR_RAM = 3'd4;

  // serially loaded register select, address bits 14:13
  localparam logic [1:0] SEL_CTRL    = 2'd0;
  localparam logic [1:0] SEL_CHR_LO  = 2'd1;
  localparam logic [1:0] SEL_CHR_HI  = 2'd2;
  localparam logic [1:0] SEL_PRG     = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_PRG_ROM_BANKS = 2'd0;
  localparam logic [1:0] REG_HAS_PRG_RAM   = 2'd1;
  localparam logic [1:0] REG_CHR_IS_RAM    = 2'd2;

  localparam logic [4:0] SHIFT_START  = 5'b10000;
  localparam logic [4:0] CFG_BANKS_RST = 5'd2;

endpackage
`default_nettype wire

@@ rtl/core/slbm_cfg.sv @@
// APB configuration registers of the bank mapper.
`default_nettype none
module slbm_cfg
  import slbm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output cfg_t             cfg
);

  logic       wr;
  logic [1:0] idx;

  assign idx = paddr[3:2];
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prg_rom_banks <= CFG_BANKS_RST;
      cfg.has_prg_ram   <= 1'b1;
      cfg.chr_is_ram    <= 1'b0;
    end else if (wr) begin
      case (idx)
        REG_PRG_ROM_BANKS: cfg.prg_rom_banks <= pwdata[4:0];
        REG_HAS_PRG_RAM:   cfg.has_prg_ram   <= pwdata[0];
        REG_CHR_IS_RAM:    cfg.chr_is_ram    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PRG_ROM_BANKS: prdata = {27'd0, cfg.prg_rom_banks};
      REG_HAS_PRG_RAM:   prdata = {31'd0, cfg.has_prg_ram};
      REG_CHR_IS_RAM:    prdata = {31'd0, cfg.chr_is_ram};
      default:           prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/core/slbm_regs.sv @@
// Serial shift register and the bank registers it loads.
`default_nettype none
module slbm_regs
  import slbm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        upd,
  input  req_word_t        item,
  output bank_state_t      st,
  output logic [1:0]       mirror_next
);

  logic [4:0]  shift_reg;
  logic [4:0]  shift_reg_next;
  logic [4:0]  shifted;
  bank_state_t st_next;
  logic        reg_wr;

  assign reg_wr  = upd && (item.kind == KIND_CPU_WR) && item.bus_addr[15];
  assign shifted = {item.bus_data[0], shift_reg[4:1]};

  always_comb begin
    shift_reg_next = shift_reg;
    st_next        = st;
    if (reg_wr) begin
      if (item.bus_data[7]) begin
        shift_reg_next = SHIFT_START;
      end else if (shift_reg[0]) begin
        // marker reached bit 0: fifth bit, commit
        shift_reg_next = SHIFT_START;
        case (item.bus_addr[14:13])
          SEL_CTRL: begin
            st_next.mirror_sel    = shifted[1:0];
            st_next.prg_bank_mode = shifted[3:2];
            st_next.chr_bank_mode = shifted[4];
          end
          SEL_CHR_LO: st_next.chr_bank_lo = shifted;
          SEL_CHR_HI: st_next.chr_bank_hi = shifted;
          SEL_PRG: begin
            st_next.prg_bank   = shifted[3:0];
            st_next.prg_ram_on = ~shifted[4];
          end
          default: ;
        endcase
      end else begin
        shift_reg_next = shifted;
      end
    end
  end

  assign mirror_next = st_next.mirror_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_reg        <= SHIFT_START;
      st.mirror_sel    <= 2'd0;
      st.prg_bank_mode <= 2'd3;
      st.chr_bank_mode <= 1'b0;
      st.chr_bank_lo   <= 5'd0;
      st.chr_bank_hi   <= 5'd0;
      st.prg_bank      <= 4'd0;
      st.prg_ram_on    <= 1'b1;
    end else begin
      shift_reg <= shift_reg_next;
      st        <= st_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/slbm_xlate.sv @@
// Address translation of one bus access into a memory and byte address.
`default_nettype none
module slbm_xlate
  import slbm_pkg::*;
#(
  parameter int MAX_PRG_BANKS = 16
) (
  input  req_word_t   item,
  input  bank_state_t st,
  input  cfg_t        cfg,
  input  wire logic [1:0] mirroring,
  output rsp_word_t   res
);

  localparam logic [4:0] MAX_BANKS = 5'(MAX_PRG_BANKS);

  logic [4:0]  n_clamp;
  logic [4:0]  banks;
  logic [3:0]  banks_m1;
  logic [17:0] rom_mask;
  logic [17:0] rom_raw;
  logic [13:0] off;
  logic [16:0] chr_a;
  logic        ram_hit;
  logic [15:0] a;

  assign a   = item.bus_addr;
  assign off = a[13:0];

  // effective bank count: clamp to 1..MAX, round down to a power of two
  always_comb begin
    n_clamp = cfg.prg_rom_banks;
    if (n_clamp == 5'd0) n_clamp = 5'd1;
    if (n_clamp > MAX_BANKS) n_clamp = MAX_BANKS;
    banks = 5'd1;
    for (int i = 1; i < 5; i++) begin
      if (n_clamp[i]) banks = 5'd1 << i;
    end
  end

  assign banks_m1 = 4'(banks - 5'd1);
  assign rom_mask = {banks_m1, 14'h3FFF};

  always_comb begin
    if (!st.prg_bank_mode[1]) begin
      rom_raw = {st.prg_bank[3:1], a[14:0]};
    end else if (!a[14]) begin
      // 0x8000-0xBFFF
      rom_raw = st.prg_bank_mode[0] ? {st.prg_bank, off} : {4'd0, off};
    end else begin
      rom_raw = st.prg_bank_mode[0] ? {banks_m1, off} : {st.prg_bank, off};
    end
  end

  always_comb begin
    if (!st.chr_bank_mode) chr_a = {st.chr_bank_lo[4:1], a[12:0]};
    else if (!a[12])       chr_a = {st.chr_bank_lo, a[11:0]};
    else                   chr_a = {st.chr_bank_hi, a[11:0]};
  end

  assign ram_hit = (a[15:13] == 3'b011) && cfg.has_prg_ram && st.prg_ram_on;

  always_comb begin
    res.target       = TGT_NONE;
    res.mem_addr     = 18'd0;
    res.write_enable = 1'b0;
    res.write_byte   = 8'd0;
    res.mirroring    = mirroring;
    case (item.kind)
      KIND_CPU_WR: begin
        if (!a[15] && ram_hit) begin
          res.target       = TGT_PRG_RAM;
          res.mem_addr     = {5'd0, a[12:0]};
          res.write_enable = 1'b1;
          res.write_byte   = item.bus_data;
        end
      end
      KIND_CPU_RD: begin
        if (a[15]) begin
          res.target   = TGT_PRG_ROM;
          res.mem_addr = rom_raw & rom_mask;
        end else if (ram_hit) begin
          res.target   = TGT_PRG_RAM;
          res.mem_addr = {5'd0, a[12:0]};
        end
      end
      KIND_VID_RD: begin
        res.target   = cfg.chr_is_ram ? TGT_CHR_RAM : TGT_CHR_ROM;
        res.mem_addr = {1'b0, chr_a};
      end
      KIND_VID_WR: begin
        if (cfg.chr_is_ram) begin
          res.target       = TGT_CHR_RAM;
          res.mem_addr     = {1'b0, chr_a};
          res.write_enable = 1'b1;
          res.write_byte   = item.bus_data;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/core/serial_loaded_bank_mapper.sv @@
// Serial-loaded bank mapper top level: input register, translation, result register.
// Usage:
//   req channel: one bus access word (kind, bus_addr, bus_data) per handshake.
//   rsp channel: one result word per access (target, mem_addr, write_enable,
//   write_byte, mirroring), in access order.
//   APB port: prg_rom_banks at 0x0, has_prg_ram at 0x4, chr_is_ram at 0x8;
//   write only while no access is in flight.
// Pipeline: an accepted word is held in the input register, then in the result register on rsp.
// Throughput: one word per cycle while rsp is not stalled; translation is a single
//   combinational pass between the input register and the result register.
// Serial register writes update the bank state when the word leaves the input
//   register, so the next word already sees the new banks and mirroring.
// Reset: bank state returns to its power-on values (last bank fixed, RAM on),
//   both pipeline registers empty, configuration back to defaults.
// Stall: while rsp_ready is low the result holds; the input register still
//   takes one more word, after which req_ready drops.
`default_nettype none
module serial_loaded_bank_mapper
  import slbm_pkg::*;
#(
  parameter int MAX_PRG_BANKS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_ready,
  input  req_word_t        req,
  output logic             rsp_valid,
  input  wire logic        rsp_ready,
  output rsp_word_t        rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t        cfg;
  bank_state_t st;
  logic [1:0]  mirror_next;
  logic        s1_valid;
  req_word_t   s1_word;
  logic        advance;
  rsp_word_t   res;

  assign pready    = 1'b1;
  assign advance   = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || advance;

  slbm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  slbm_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .upd         (advance),
    .item        (s1_word),
    .st          (st),
    .mirror_next (mirror_next)
  );

  slbm_xlate #(
    .MAX_PRG_BANKS (MAX_PRG_BANKS)
  ) u_xlate (
    .item      (s1_word),
    .st        (st),
    .cfg       (cfg),
    .mirroring (mirror_next),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      s1_word <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= res;
    end
  end

  a_we_target : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.write_enable |->
      (rsp.target == TGT_PRG_RAM || rsp.target == TGT_CHR_RAM))
    else $error("write enable on a read-only or empty target");

  a_none_zero : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.target == TGT_NONE |->
      (rsp.mem_addr == 18'd0 && !rsp.write_enable))
    else $error("ignored access carries an address or write");

  a_rst_empty : assert property (@(posedge clk)
    rst |=> !rsp_valid && !s1_valid)
    else $error("pipeline not empty after reset");

  a_stall_full : assert property (@(posedge clk) disable iff (rst)
    s1_valid && rsp_valid && !rsp_ready |-> !req_ready)
    else $error("input taken with both stages full");

endmodule
`default_nettype wire
